### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property forms for the checker modules, clocked on i_clk and
// switched off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define A85_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("a85 check failed");

// next-cycle implication
`define A85_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("a85 check failed");

`endif

### rtl/core/a85_pkg.sv
// ----------------------------------------------------------------------------
// a85_pkg
// types and constants shared by the ascii85 encoder modules
// ----------------------------------------------------------------------------
package a85_pkg;

    localparam int CHAR_W  = 7;
    localparam int BYTE_W  = 8;
    localparam int VAL_W   = 32;
    localparam int NDIG    = 5;
    localparam int NSTEP   = NDIG - 1;
    localparam int GROUP_N = 4;
    localparam int Q_DEPTH = 2;

    // floor(v / 85) == (v * RECIP_MAGIC) >> RECIP_SHIFT for any 32-bit v
    localparam int          PROD_W      = 2 * VAL_W;
    localparam int          RECIP_SHIFT = 38;
    localparam int          Q_W         = PROD_W - RECIP_SHIFT;
    localparam logic [31:0] RECIP_MAGIC = 32'd3233857729;

    localparam logic [CHAR_W-1:0] BASE     = 7'd85;
    localparam logic [CHAR_W-1:0] OFFSET   = 7'd33;
    localparam logic [CHAR_W-1:0] CH_Z     = 7'h7A;
    localparam logic [CHAR_W-1:0] CH_TILDE = 7'h7E;
    localparam logic [CHAR_W-1:0] CH_GT    = 7'h3E;
    localparam logic [CHAR_W-1:0] CH_NL    = 7'h0A;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last;
    } t_out_word;

    typedef logic [NDIG-1:0][CHAR_W-1:0] t_digs;

    // one unit of output work: digits of a value, a 'z', and/or the trailer
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [2:0]       ndig;
        logic             zero;
        logic             trailer;
    } t_job;

    typedef struct packed {
        t_job  job;
        t_digs digs;
    } t_work;

endpackage

### rtl/core/a85_fifo.sv
// ----------------------------------------------------------------------------
// a85_fifo
// short job queue between the byte gatherer and the conversion back end
// ----------------------------------------------------------------------------
module a85_fifo #(
    parameter int DEPTH = a85_pkg::Q_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  a85_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output a85_pkg::t_job o_job,
    input  logic          i_pop
);
    import a85_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

### rtl/core/a85_front.sv
// ----------------------------------------------------------------------------
// a85_front
// accepts input words, gathers bytes into groups and issues output jobs
// ----------------------------------------------------------------------------
module a85_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  a85_pkg::t_in_word i_data,
    output logic              o_stall,
    output logic              o_push,
    output a85_pkg::t_job     o_job,
    input  logic              i_full
);
    import a85_pkg::*;

    logic [BYTE_W-1:0] r_bytes [GROUP_N-1];
    logic [1:0]        r_cnt;
    logic              acc;
    logic [VAL_W-1:0]  full_val;
    logic [VAL_W-1:0]  pad_val;

    assign o_stall = i_full;
    assign acc     = i_valid && !i_full;

    always_comb begin
        full_val = {r_bytes[0], r_bytes[1], r_bytes[2], i_data.data_byte};
        // bytes beyond the fill level are padded with zero
        pad_val  = {r_bytes[0],
                    (r_cnt > 2'd1) ? r_bytes[1] : 8'h00,
                    (r_cnt > 2'd2) ? r_bytes[2] : 8'h00,
                    8'h00};
        o_push   = 1'b0;
        o_job    = '0;
        if (acc) begin
            if (i_data.cmd == CMD_DATA) begin
                if (r_cnt == 2'd3) begin
                    o_push        = 1'b1;
                    o_job.value   = full_val;
                    o_job.zero    = (full_val == '0);
                    o_job.ndig    = (full_val == '0) ? 3'd0 : 3'(NDIG);
                    o_job.trailer = 1'b0;
                end
            end else begin
                o_push        = 1'b1;
                o_job.value   = pad_val;
                o_job.zero    = 1'b0;
                o_job.ndig    = (r_cnt == 2'd0) ? 3'd0 : 3'(r_cnt) + 3'd1;
                o_job.trailer = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (acc) begin
            if (i_data.cmd == CMD_DATA) begin
                r_cnt <= r_cnt + 2'd1;
            end else begin
                r_cnt <= '0;
            end
        end
        if (acc && i_data.cmd == CMD_DATA && r_cnt != 2'd3) begin
            r_bytes[r_cnt] <= i_data.data_byte;
        end
    end

endmodule

### rtl/core/a85_conv.sv
// ----------------------------------------------------------------------------
// a85_conv
// pipelined base-85 conversion: four divide-by-85 steps, each a reciprocal
// multiply stage followed by a quotient and remainder stage
// ----------------------------------------------------------------------------
module a85_conv (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  a85_pkg::t_work i_work,
    output logic           o_pop,
    output logic           o_valid,
    output a85_pkg::t_work o_work,
    input  logic           i_take
);
    import a85_pkg::*;

    logic              r_av   [NSTEP];
    t_work             r_a    [NSTEP];
    logic [PROD_W-1:0] r_prod [NSTEP];
    logic              r_bv   [NSTEP];
    t_work             r_b    [NSTEP];

    logic              st_v   [NSTEP];
    t_work             st_w   [NSTEP];
    t_work             n_b    [NSTEP];
    logic [Q_W-1:0]    quo    [NSTEP];
    logic [CHAR_W-1:0] q85    [NSTEP];
    logic              en;

    // whole pipe holds while the last stage waits on the emitter
    assign en    = !r_bv[NSTEP-1] || i_take;
    assign o_pop = i_valid && en;

    always_comb begin
        for (int k = 0; k < NSTEP; k++) begin
            if (k == 0) begin
                st_v[k] = i_valid;
                st_w[k] = i_work;
            end else begin
                st_v[k] = r_bv[k-1];
                st_w[k] = r_b[k-1];
            end
            quo[k] = r_prod[k][PROD_W-1 -: Q_W];
            // only the low bits of q*85 matter for a remainder below 85
            q85[k] = quo[k][CHAR_W-1:0] * BASE;
            n_b[k] = r_a[k];
            n_b[k].job.value = {{(VAL_W-Q_W){1'b0}}, quo[k]};
            n_b[k].digs[NDIG-1-k] = r_a[k].job.value[CHAR_W-1:0] - q85[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTEP; k++) begin
                r_av[k] <= 1'b0;
                r_bv[k] <= 1'b0;
            end
        end else if (en) begin
            for (int k = 0; k < NSTEP; k++) begin
                r_av[k] <= st_v[k];
                r_bv[k] <= r_av[k];
            end
        end
        if (en) begin
            for (int k = 0; k < NSTEP; k++) begin
                r_a[k]    <= st_w[k];
                r_prod[k] <= PROD_W'(st_w[k].job.value) * PROD_W'(RECIP_MAGIC);
                r_b[k]    <= n_b[k];
            end
        end
    end

    always_comb begin
        o_valid = r_bv[NSTEP-1];
        o_work  = r_b[NSTEP-1];
        // what is left after four divisions is the leading digit
        o_work.digs[0] = r_b[NSTEP-1].job.value[CHAR_W-1:0];
    end

endmodule

### rtl/core/a85_emit.sv
// ----------------------------------------------------------------------------
// a85_emit
// serialises one job into characters, one per cycle, through an output
// register that the receiver may stall
// ----------------------------------------------------------------------------
module a85_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  a85_pkg::t_work     i_work,
    output logic               o_take,
    output logic               o_valid,
    output a85_pkg::t_out_word o_data,
    input  logic               i_stall
);
    import a85_pkg::*;

    logic              r_busy;
    logic [2:0]        r_pos;
    t_work             r_work;
    logic              r_ovld;
    t_out_word         r_out;

    logic              n_busy;
    logic [2:0]        tot;
    logic [2:0]        tidx;
    logic              lastc;
    logic              adv;
    logic              emit;
    logic [CHAR_W-1:0] ch;

    always_comb begin
        tot   = r_work.job.ndig + {2'b00, r_work.job.zero}
              + (r_work.job.trailer ? 3'd3 : 3'd0);
        lastc = (r_pos == tot - 3'd1);
        adv   = !r_ovld || !i_stall;
        emit  = r_busy && adv;
        o_take = i_valid && (!r_busy || (emit && lastc));
        tidx  = r_pos - r_work.job.ndig;
        if (r_pos < r_work.job.ndig) begin
            ch = r_work.digs[r_pos] + OFFSET;
        end else if (r_work.job.zero) begin
            ch = CH_Z;
        end else begin
            case (tidx)
                3'd0:    ch = CH_TILDE;
                3'd1:    ch = CH_GT;
                default: ch = CH_NL;
            endcase
        end
        n_busy = r_busy;
        if (emit && lastc) begin
            n_busy = 1'b0;
        end
        if (o_take) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ovld <= 1'b0;
            r_pos  <= '0;
        end else begin
            r_busy <= n_busy;
            if (adv) begin
                r_ovld <= emit;
            end
            if (o_take) begin
                r_pos <= '0;
            end else if (emit) begin
                r_pos <= r_pos + 3'd1;
            end
        end
        if (emit) begin
            r_out.out_char <= ch;
            r_out.last     <= lastc;
        end
        if (o_take) begin
            r_work <= i_work;
        end
    end

    assign o_valid = r_ovld;
    assign o_data  = r_out;

endmodule

### rtl/core/ascii85_encoder.sv
// ----------------------------------------------------------------------------
// ascii85_encoder
// byte stream to ascii85 character stream encoder
// ----------------------------------------------------------------------------
// input channel (i_valid, i_data, o_stall): one word per byte to append
// (cmd = data) or a flush (cmd = flush). the input side only stalls when
// the job queue between the gatherer and the back end is full.
// output channel (o_valid, o_data, i_stall): one character per word, with
// last set on the final character caused by an input word.
// a byte that completes a group gives five digits or a single 'z'; a flush
// gives the digits of any partial group and then '~', '>' and newline.
// the first character of a word passes through the queue, the
// eight-stage divide-by-85 pipeline and the output register.
// throughput: one character per cycle from the emitter while i_stall
// is low and the emitter holds a job.
// reset clears the group fill level, the queue, the pipeline and the
// output register. while i_stall is high the output word holds, the
// pipeline and queue back up, and then o_stall rises.
// ----------------------------------------------------------------------------
module ascii85_encoder #(
    parameter int QUEUE_DEPTH = a85_pkg::Q_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  a85_pkg::t_in_word  i_data,
    output logic               o_stall,
    output logic               o_valid,
    output a85_pkg::t_out_word o_data,
    input  logic               i_stall
);
    import a85_pkg::*;

    logic  push;
    t_job  push_job;
    logic  q_full;
    logic  q_valid;
    t_job  q_job;
    logic  q_pop;
    t_work conv_in;
    logic  cv_valid;
    t_work cv_work;
    logic  em_take;

    a85_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (q_full)
    );

    a85_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    always_comb begin
        conv_in.job  = q_job;
        conv_in.digs = '0;
    end

    a85_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_work  (conv_in),
        .o_pop   (q_pop),
        .o_valid (cv_valid),
        .o_work  (cv_work),
        .i_take  (em_take)
    );

    a85_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cv_valid),
        .i_work  (cv_work),
        .o_take  (em_take),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule

### rtl/core/a85_checker.sv
// ----------------------------------------------------------------------------
// a85_checker
// port-level checks on the ascii85 encoder output stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module a85_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input a85_pkg::t_in_word  i_data,
    input logic               o_stall,
    input logic               o_valid,
    input a85_pkg::t_out_word o_data,
    input logic               i_stall
);
    import a85_pkg::*;

    `A85_CHECK_NEXT(a_in_hold, i_valid && o_stall, i_valid && $stable(i_data))
    `A85_CHECK_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_data))
    // a 'z' stands for a whole group, so it always closes its word
    `A85_CHECK(a_z_last, o_valid && o_data.out_char == CH_Z, o_data.last)
    `A85_CHECK(a_nl_last, o_valid && o_data.out_char == CH_NL, o_data.last)
    // '>' doubles as a digit, so only the tilde is known to sit mid-trailer
    `A85_CHECK(a_trl_mid, o_valid && o_data.out_char == CH_TILDE, !o_data.last)

endmodule

bind ascii85_encoder a85_checker u_a85_checker (.*);
